[rtl/scra_pkg.sv]
// Package for the sample compare running average block.
// Holds the data width, divider counter width and relation codes.
// No dependencies.
package scra_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

    typedef enum logic [1:0] {
        REL_GREATER = 2'd0,
        REL_EQUAL   = 2'd1,
        REL_LESS    = 2'd2,
        REL_FIRST   = 2'd3
    } rel_t;

endpackage

[rtl/scra_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle through one shared subtractor.
// Depends on scra_pkg for DATA_W and CNT_W.
module scra_div
    import scra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  step_reg;
    logic [CNT_W-1:0]  step_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] quo_next;
    logic [DATA_W-1:0] dvsr_reg;
    logic [DATA_W-1:0] dvsr_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;

    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvsr_next = dvsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvsr_next = divisor;
        end
        else if (busy_reg)
        begin
            // restore when the trial subtract borrows
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvsr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvsr_reg <= dvsr_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider not busy after start");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without prior iteration");
`endif

endmodule

[rtl/sample_compare_running_average.sv]
// Sample compare running average: top level with sequencer, state and output register.
// Depends on scra_pkg and scra_div.
//
// Usage:
//   Input channel: in_valid / in_stall with one 32-bit sample per transaction;
//   only the low SAMPLE_WIDTH bits are used.
//   Output channel: out_valid / out_stall carrying relation, average,
//   sample_count and sum_saturated, one transaction per input transaction.
//   The first sample after reset reports relation 3 and seeds the sum and a
//   count of one; later samples report greater (0), equal (1) or less (2)
//   against the previous sample.
//   The radix-2 divider produces one quotient bit per cycle on its shared
//   subtractor, and the finished quotient is registered into the output register.
//   A new sample waits until the divide of the previous one is done; in_stall
//   is high while a divide is in flight.
//   A new sample is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the finished quotient is held
//   and in_stall stays high until the output register frees up.
//   Reset clears the sequencer, the output valid and the seeded flag, so the
//   next sample is treated as the first.
module sample_compare_running_average
    import scra_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] sample,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        relation,
    output logic [DATA_W-1:0] average,
    output logic [DATA_W-1:0] sample_count,
    output logic              sum_saturated
);

    localparam logic [DATA_W:0] MASK_WIDE =
        ((DATA_W + 1)'(1) << SAMPLE_WIDTH) - (DATA_W + 1)'(1);
    localparam logic [DATA_W-1:0] SAMPLE_MASK = MASK_WIDE[DATA_W-1:0];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic              seeded_reg;
    logic              seeded_next;
    logic [DATA_W-1:0] prev_reg;
    logic [DATA_W-1:0] prev_next;
    logic [DATA_W-1:0] sum_reg;
    logic [DATA_W-1:0] sum_next;
    logic [DATA_W-1:0] count_reg;
    logic [DATA_W-1:0] count_next;
    rel_t              rel_reg;
    rel_t              rel_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    rel_t              out_rel_reg;
    rel_t              out_rel_next;
    logic [DATA_W-1:0] out_avg_reg;
    logic [DATA_W-1:0] out_avg_next;
    logic [DATA_W-1:0] out_count_reg;
    logic [DATA_W-1:0] out_count_next;
    logic              out_sat_reg;
    logic              out_sat_next;

    logic              in_accept;
    logic              out_free;
    logic              result_ready;
    logic              out_load;
    logic [DATA_W-1:0] s_masked;
    logic [DATA_W:0]   sum_wide;
    logic              div_busy;
    logic              div_done;
    logic [DATA_W-1:0] div_quotient;

    assign s_masked     = sample & SAMPLE_MASK;
    assign sum_wide     = {1'b0, sum_reg} + {1'b0, s_masked};
    assign in_stall     = (state_reg != ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign out_free     = !out_valid_reg || !out_stall;
    assign result_ready = (state_reg == ST_DIV && div_done) || (state_reg == ST_HOLD);
    assign out_load     = result_ready && out_free;

    always_comb
    begin
        seeded_next = seeded_reg;
        prev_next   = prev_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        rel_next    = rel_reg;
        if (in_accept)
        begin
            seeded_next = 1'b1;
            prev_next   = s_masked;
            if (!seeded_reg)
            begin
                rel_next   = REL_FIRST;
                sum_next   = s_masked;
                count_next = DATA_W'(1);
            end
            else
            begin
                if (s_masked > prev_reg)
                    rel_next = REL_GREATER;
                else if (s_masked == prev_reg)
                    rel_next = REL_EQUAL;
                else
                    rel_next = REL_LESS;
                if (count_reg != ALL_ONES)
                    count_next = count_reg + 1'b1;
                // saturate on carry out
                if (sum_wide[DATA_W])
                    sum_next = ALL_ONES;
                else
                    sum_next = sum_wide[DATA_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_rel_next   = out_rel_reg;
        out_avg_next   = out_avg_reg;
        out_count_next = out_count_reg;
        out_sat_next   = out_sat_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_rel_next   = rel_reg;
            out_avg_next   = div_quotient;
            out_count_next = count_reg;
            out_sat_next   = (sum_reg == ALL_ONES);
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seeded_reg    <= 1'b0;
            prev_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            rel_reg       <= REL_FIRST;
            out_valid_reg <= 1'b0;
            out_rel_reg   <= REL_FIRST;
            out_avg_reg   <= '0;
            out_count_reg <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            prev_reg      <= prev_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            rel_reg       <= rel_next;
            out_valid_reg <= out_valid_next;
            out_rel_reg   <= out_rel_next;
            out_avg_reg   <= out_avg_next;
            out_count_reg <= out_count_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    scra_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .dividend (sum_next),
        .divisor  (count_next),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_valid     = out_valid_reg;
    assign relation      = out_rel_reg;
    assign average       = out_avg_reg;
    assign sample_count  = out_count_reg;
    assign sum_saturated = out_sat_reg;

`ifndef SYNTHESIS
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> in_stall)
        else $error("input accepted while divider busy");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> count_next != '0)
        else $error("divide started with zero count");

    a_valid_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg != ST_IDLE))
        else $error("result presented without a divide");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg != '0)
        else $error("result with zero sample count");
`endif

endmodule

[test/sample_compare_running_average_tb.sv]
`timescale 1ns / 1ps
// Testbench for sample_compare_running_average: random and directed samples,
// stalls on both channels, results checked against an in-bench running mean.
// Depends on scra_pkg and the sample_compare_running_average RTL.
module sample_compare_running_average_tb;
    import scra_pkg::*;

    localparam int unsigned SAMPLE_WIDTH = 32;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned TAIL_CYCLES  = 40;

    typedef struct {
        rel_t              rel;
        logic [DATA_W-1:0] avg;
        logic [DATA_W-1:0] cnt;
        logic              sat;
    } mean_result_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [DATA_W-1:0] sample;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        relation;
    logic [DATA_W-1:0] average;
    logic [DATA_W-1:0] sample_count;
    logic              sum_saturated;

    logic [DATA_W-1:0] pending_samples[$];
    mean_result_t      expected_results[$];

    logic [DATA_W-1:0] last_sample;
    logic [DATA_W-1:0] sum_acc;
    logic [DATA_W-1:0] sample_cnt;
    bit                have_seed;

    bit                in_fired;
    int unsigned       in_gap;
    int unsigned       out_gap;
    int unsigned       in_idle_pct;
    int unsigned       out_idle_pct;
    int unsigned       mismatches;
    int unsigned       cycles;
    logic [DATA_W-1:0] prev_pushed;

    sample_compare_running_average #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .relation     (relation),
        .average      (average),
        .sample_count (sample_count),
        .sum_saturated(sum_saturated)
    );

    function automatic mean_result_t mean_step(logic [DATA_W-1:0] raw);
        logic [DATA_W-1:0] s;
        logic [DATA_W:0]   wide_sum;
        mean_result_t      r;
        s = raw & DATA_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);
        if (!have_seed)
        begin
            r.rel      = REL_FIRST;
            sum_acc    = s;
            sample_cnt = DATA_W'(1);
            have_seed  = 1'b1;
        end
        else
        begin
            if (s > last_sample)
                r.rel = REL_GREATER;
            else if (s == last_sample)
                r.rel = REL_EQUAL;
            else
                r.rel = REL_LESS;
            if (sample_cnt != ALL_ONES)
                sample_cnt = sample_cnt + 1'b1;
            wide_sum = {1'b0, sum_acc} + {1'b0, s};
            sum_acc  = wide_sum[DATA_W] ? ALL_ONES : wide_sum[DATA_W-1:0];
        end
        last_sample = s;
        r.avg = sum_acc / sample_cnt;
        r.cnt = sample_cnt;
        r.sat = (sum_acc == ALL_ONES);
        return r;
    endfunction

    task automatic push_sample(logic [DATA_W-1:0] s);
        pending_samples.push_back(s);
        prev_pushed = s;
    endtask

    task automatic push_random(int unsigned n, bit full_range);
        logic [DATA_W-1:0] s;
        repeat (n)
        begin
            if ($urandom_range(7) == 0)
                s = prev_pushed;
            else if (full_range)
                s = $urandom;
            else
                s = $urandom >> $urandom_range(12, 31);
            push_sample(s);
        end
    endtask

    task automatic drain_all();
        while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // input side: predict on each accepted transaction
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_results.push_back(mean_step(sample));
            in_fired = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        logic              nxt_valid;
        logic [DATA_W-1:0] nxt_sample;
        nxt_valid  = in_valid;
        nxt_sample = sample;
        if (rst_n && (!in_valid || in_fired))
        begin
            nxt_valid = 1'b0;
            if (in_gap != 0)
                in_gap--;
            else if (pending_samples.size() != 0)
            begin
                if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct)
                    in_gap = $urandom_range(1, 15) - 1;
                else
                begin
                    nxt_valid  = 1'b1;
                    nxt_sample = pending_samples.pop_front();
                end
            end
        end
        in_fired = 1'b0;
        in_valid <= nxt_valid;
        sample   <= nxt_sample;
    end

    always @(negedge clk)
    begin
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (rst_n)
        begin
            if (out_gap != 0)
            begin
                nxt_stall = 1'b1;
                out_gap--;
            end
            else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct)
            begin
                nxt_stall = 1'b1;
                out_gap   = $urandom_range(1, 15) - 1;
            end
        end
        out_stall <= nxt_stall;
    end

    // output side: compare each transaction with the oldest expectation
    always @(posedge clk)
    begin
        mean_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: relation %0d average %0h", relation, average);
                mismatches++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (relation !== e.rel)
                begin
                    $error("relation: expected %0d, actual %0d", e.rel, relation);
                    mismatches++;
                end
                if (average !== e.avg)
                begin
                    $error("average: expected %0h, actual %0h", e.avg, average);
                    mismatches++;
                end
                if (sample_count !== e.cnt)
                begin
                    $error("sample_count: expected %0d, actual %0d", e.cnt, sample_count);
                    mismatches++;
                end
                if (sum_saturated !== e.sat)
                begin
                    $error("sum_saturated: expected %0b, actual %0b", e.sat, sum_saturated);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        sample       = '0;
        out_stall    = 1'b0;
        in_fired     = 1'b0;
        in_gap       = 0;
        out_gap      = 0;
        in_idle_pct  = 25;
        out_idle_pct = 25;
        mismatches   = 0;
        cycles       = 0;
        have_seed    = 1'b0;
        last_sample  = '0;
        sum_acc      = '0;
        sample_cnt   = '0;
        prev_pushed  = '0;

        // seed, equal, greater, less, then small bit patterns
        push_sample(32'd0);
        push_sample(32'd0);
        push_sample(32'd1);
        push_sample(32'd0);
        push_sample(32'd3);
        push_sample(32'd3);
        push_sample(32'h0000_FFFF);
        push_sample(32'h000F_0F0F);
        push_sample(32'h00AA_AAAA);
        push_sample(32'h0055_5555);
        push_sample(32'h0000_0001);
        push_random(400, 1'b0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        drain_all();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        push_random(100, 1'b0);
        drain_all();

        // walk the sum up to exactly all ones, then hold there and overflow
        in_idle_pct  = 20;
        out_idle_pct = 30;
        push_sample(ALL_ONES - sum_acc - 1'b1);
        push_sample(32'd1);
        push_sample(32'd0);
        push_sample(ALL_ONES);
        push_sample(ALL_ONES);
        push_sample(32'h8000_0000);
        push_sample(32'h5555_5555);
        push_sample(32'hAAAA_AAAA);
        push_sample(32'd0);
        push_random(150, 1'b1);
        drain_all();

        in_idle_pct  = 0;
        out_idle_pct = 0;
        push_random(60, 1'b1);
        drain_all();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
rtl/scra_pkg.sv
rtl/scra_div.sv
rtl/sample_compare_running_average.sv
test/sample_compare_running_average_tb.sv
